@@ hdl/rvrd_pkg.sv @@
package rvrd_pkg;

    localparam int MAX_LINES_DEFAULT = 8;
    localparam int MAX_LINES_LIMIT   = 64;

    localparam int RTP_HEADER_BYTES = 12;
    localparam int EXT_SEQ_BYTES    = 2;
    localparam int LINE_HDR_BYTES   = 6;

    localparam int BYTE_W   = 8;
    localparam int ADDR_W   = 29;
    localparam int PITCH_W  = 13;
    localparam int LEN_W    = 16;
    localparam int ROW_W    = 15;
    localparam int OFFS_W   = 15;
    localparam int HCNT_W   = 4;
    localparam int ERR_W    = 2;

    localparam logic [PITCH_W-1:0] PITCH_RESET = PITCH_W'(640);

    // APB register map: one 32-bit register per 4-byte slot
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_LINE_PITCH = 1'b0;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE           = 2'd0,
        ERR_TOO_MANY_LINES = 2'd1,
        ERR_TRUNCATED      = 2'd2
    } err_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [ROW_W-1:0]  row;
        logic [OFFS_W-1:0] offs;
    } line_entry_t;

endpackage

@@ hdl/rvrd_if.sv @@
interface rvrd_in_if;
    logic                        valid;
    logic                        ready;
    logic [rvrd_pkg::BYTE_W-1:0] payload_byte;
    logic                        packet_last;

    modport source (output valid, output payload_byte, output packet_last, input ready);
    modport sink   (input valid, input payload_byte, input packet_last, output ready);
endinterface

interface rvrd_out_if;
    logic                        valid;
    logic                        ready;
    logic                        write_valid;
    logic [rvrd_pkg::ADDR_W-1:0] write_address;
    logic [rvrd_pkg::BYTE_W-1:0] write_byte;
    logic                        frame_end;
    logic [rvrd_pkg::ERR_W-1:0]  packet_error;

    modport source (
        output valid, output write_valid, output write_address, output write_byte,
        output frame_end, output packet_error, input ready
    );
    modport sink (
        input valid, input write_valid, input write_address, input write_byte,
        input frame_end, input packet_error, output ready
    );
endinterface

@@ hdl/raw_video_rtp_depacketizer.sv @@
// Pipeline: a result word passes the s1, s2 and out registers on its way to fb.
// Throughput: one payload byte per cycle while fb takes results; the line table is read into
//   rd_reg at the index the next byte will use, so line switches do not stall the input.
// Words that cause no result (headers, trailing bytes) leave nothing in the output pipe.
// Reset: parser, pipeline valids and pitch (640) clear at once; the line table is
//   not cleared and is only read at entries written earlier in the same packet.
module raw_video_rtp_depacketizer #(
    parameter int MAX_LINES = rvrd_pkg::MAX_LINES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rvrd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rvrd_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rvrd_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    rvrd_in_if.sink                         pkt,
    rvrd_out_if.source                      fb
);

    localparam int IW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CW = $clog2(MAX_LINES + 1);
    localparam int PROD_W = rvrd_pkg::ROW_W + rvrd_pkg::PITCH_W;
    localparam int OFS_W  = rvrd_pkg::LEN_W + 1;

    typedef enum logic [2:0] {
        PH_RTP,
        PH_EXT,
        PH_LINES,
        PH_DATA,
        PH_DONE,
        PH_SKIP
    } phase_t;

    // lowest set bit: {found, index}
    function automatic logic [IW:0] find_first(input logic [MAX_LINES-1:0] vec);
        logic [IW:0] res;
        res = '0;
        for (int i = MAX_LINES - 1; i >= 0; i--) begin
            if (vec[i]) begin
                res = {1'b1, IW'(i)};
            end
        end
        return res;
    endfunction

    // ---------------- configuration ----------------
    logic [rvrd_pkg::PITCH_W-1:0] pitch_reg;
    logic                         cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == rvrd_pkg::REG_LINE_PITCH);
    assign prdata    = (paddr[2] == rvrd_pkg::REG_LINE_PITCH)
                     ? rvrd_pkg::APB_DATA_W'(pitch_reg) : '0;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            pitch_reg <= rvrd_pkg::PITCH_RESET;
        end
        else if (cfg_write)
        begin
            pitch_reg <= pwdata[rvrd_pkg::PITCH_W-1:0];
        end
    end

    // ---------------- parser state ----------------
    phase_t                       phase_reg, phase_next;
    logic [rvrd_pkg::HCNT_W-1:0]  hcnt_reg, hcnt_next;
    logic                         marker_reg, marker_next;
    logic [39:0]                  hdr_reg, hdr_next;
    logic [CW-1:0]                line_total_reg, line_total_next;
    logic [IW-1:0]                line_cur_reg, line_cur_next;
    logic [rvrd_pkg::LEN_W-1:0]   pos_reg, pos_next;
    logic [MAX_LINES-1:0]         nz_mask_reg, nz_mask_next;

    // line table
    rvrd_pkg::line_entry_t line_mem [MAX_LINES];
    rvrd_pkg::line_entry_t rd_reg;
    rvrd_pkg::line_entry_t mem_wdata;
    logic                  mem_we;
    logic [IW-1:0]         mem_waddr;

    logic                         pkt_acc;
    logic [rvrd_pkg::BYTE_W-1:0]  b;
    logic                         more;
    logic [MAX_LINES-1:0]         hdr_mask;
    logic [MAX_LINES-1:0]         above_mask;
    logic [MAX_LINES-1:0]         seek_vec;
    logic [IW:0]                  seek_res;
    logic                         do_seek;
    logic                         wv;
    rvrd_pkg::err_t               err;

    // output pipe
    logic s1_ready, s2_ready, out_ready;
    logic s1_valid_reg, s2_valid_reg, out_valid_reg;

    assign pkt_acc   = pkt.valid && pkt.ready;
    assign b         = pkt.payload_byte;
    assign mem_waddr = line_total_reg[IW-1:0];
    assign more      = hdr_reg[7];

    // completed header: bytes 0..4 sit in hdr_reg, byte 5 is the current word
    assign mem_wdata.len  = hdr_reg[39:24];
    assign mem_wdata.row  = hdr_reg[22:8];
    assign mem_wdata.offs = {hdr_reg[6:0], b};

    always_comb
    begin
        hdr_mask = nz_mask_reg;
        if (mem_wdata.len != '0) begin
            hdr_mask[mem_waddr] = 1'b1;
        end
        for (int i = 0; i < MAX_LINES; i++) begin
            above_mask[i] = nz_mask_reg[i] && ((IW + 1)'(i) > {1'b0, line_cur_reg});
        end
        seek_vec = (phase_reg == PH_LINES) ? hdr_mask : above_mask;
        seek_res = find_first(seek_vec);
    end

    always_comb
    begin
        phase_next      = phase_reg;
        hcnt_next       = hcnt_reg;
        marker_next     = marker_reg;
        hdr_next        = hdr_reg;
        line_total_next = line_total_reg;
        line_cur_next   = line_cur_reg;
        pos_next        = pos_reg;
        nz_mask_next    = nz_mask_reg;
        mem_we          = 1'b0;
        do_seek         = 1'b0;
        wv              = 1'b0;
        err             = rvrd_pkg::ERR_NONE;

        if (pkt_acc)
        begin
            unique case (phase_reg)
                PH_RTP:
                begin
                    if (hcnt_reg == rvrd_pkg::HCNT_W'(1)) begin
                        marker_next = b[7];
                    end
                    if (hcnt_reg == rvrd_pkg::HCNT_W'(rvrd_pkg::RTP_HEADER_BYTES - 1))
                    begin
                        hcnt_next  = '0;
                        phase_next = PH_EXT;
                    end
                    else
                    begin
                        hcnt_next = hcnt_reg + 1'b1;
                    end
                end
                PH_EXT:
                begin
                    if (hcnt_reg == rvrd_pkg::HCNT_W'(rvrd_pkg::EXT_SEQ_BYTES - 1))
                    begin
                        hcnt_next  = '0;
                        phase_next = PH_LINES;
                    end
                    else
                    begin
                        hcnt_next = hcnt_reg + 1'b1;
                    end
                end
                PH_LINES:
                begin
                    hdr_next = {hdr_reg[31:0], b};
                    if (hcnt_reg == rvrd_pkg::HCNT_W'(rvrd_pkg::LINE_HDR_BYTES - 1))
                    begin
                        hcnt_next       = '0;
                        mem_we          = 1'b1;
                        nz_mask_next    = hdr_mask;
                        line_total_next = line_total_reg + 1'b1;
                        if (!more)
                        begin
                            do_seek = 1'b1;
                        end
                        else if (line_total_reg == CW'(MAX_LINES - 1))
                        begin
                            phase_next = PH_SKIP;
                        end
                    end
                    else
                    begin
                        hcnt_next = hcnt_reg + 1'b1;
                    end
                end
                PH_DATA:
                begin
                    wv = 1'b1;
                    if (pos_reg + 1'b1 == rd_reg.len)
                    begin
                        do_seek = 1'b1;
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                PH_DONE, PH_SKIP:
                begin
                end
                default:
                begin
                end
            endcase

            if (do_seek)
            begin
                pos_next = '0;
                if (seek_res[IW])
                begin
                    phase_next    = PH_DATA;
                    line_cur_next = seek_res[IW-1:0];
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end

            if (pkt.packet_last)
            begin
                priority if (phase_next == PH_SKIP)
                begin
                    err = rvrd_pkg::ERR_TOO_MANY_LINES;
                end
                else if (phase_next == PH_DONE)
                begin
                    err = rvrd_pkg::ERR_NONE;
                end
                else
                begin
                    err = rvrd_pkg::ERR_TRUNCATED;
                end
                // restart per-packet state
                phase_next      = PH_RTP;
                hcnt_next       = '0;
                line_total_next = '0;
                line_cur_next   = '0;
                pos_next        = '0;
                nz_mask_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            phase_reg      <= PH_RTP;
            hcnt_reg       <= '0;
            marker_reg     <= 1'b0;
            line_total_reg <= '0;
            line_cur_reg   <= '0;
            pos_reg        <= '0;
            nz_mask_reg    <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            hcnt_reg       <= hcnt_next;
            marker_reg     <= (pkt_acc && pkt.packet_last) ? 1'b0 : marker_next;
            line_total_reg <= line_total_next;
            line_cur_reg   <= line_cur_next;
            pos_reg        <= pos_next;
            nz_mask_reg    <= nz_mask_next;
        end
    end

    always_ff @(posedge clk) begin
        hdr_reg <= hdr_next;
    end

    // read at the index the next word will use; forward a same-cycle write
    always_ff @(posedge clk) begin
        if (mem_we) begin
            line_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_we && (mem_waddr == line_cur_next)) begin
            rd_reg <= mem_wdata;
        end
        else begin
            rd_reg <= line_mem[line_cur_next];
        end
    end

    // ---------------- output pipe: row*pitch, then address sum ----------------
    logic                          s1_we_reg, s1_fe_reg;
    logic [rvrd_pkg::BYTE_W-1:0]   s1_byte_reg;
    logic [rvrd_pkg::ROW_W-1:0]    s1_row_reg;
    logic [rvrd_pkg::OFFS_W-1:0]   s1_offs_reg;
    logic [rvrd_pkg::LEN_W-1:0]    s1_pos_reg;
    logic [rvrd_pkg::ERR_W-1:0]    s1_err_reg;

    logic                          s2_we_reg, s2_fe_reg;
    logic [rvrd_pkg::BYTE_W-1:0]   s2_byte_reg;
    logic [PROD_W-1:0]             s2_prod_reg;
    logic [OFS_W-1:0]              s2_ofs_reg;
    logic [rvrd_pkg::ERR_W-1:0]    s2_err_reg;

    logic                          out_we_reg, out_fe_reg;
    logic [rvrd_pkg::ADDR_W-1:0]   out_addr_reg;
    logic [rvrd_pkg::BYTE_W-1:0]   out_byte_reg;
    logic [rvrd_pkg::ERR_W-1:0]    out_err_reg;

    assign out_ready = !out_valid_reg || fb.ready;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pkt.ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready) begin
                s1_valid_reg <= pkt_acc && (wv || pkt.packet_last);
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (s1_ready)
        begin
            s1_we_reg   <= wv;
            s1_byte_reg <= wv ? b : '0;
            s1_row_reg  <= wv ? rd_reg.row : '0;
            s1_offs_reg <= wv ? rd_reg.offs : '0;
            s1_pos_reg  <= wv ? pos_reg : '0;
            s1_fe_reg   <= pkt.packet_last && marker_next;
            s1_err_reg  <= err;
        end
        if (s2_ready)
        begin
            s2_we_reg   <= s1_we_reg;
            s2_byte_reg <= s1_byte_reg;
            s2_prod_reg <= PROD_W'(s1_row_reg) * PROD_W'(pitch_reg);
            s2_ofs_reg  <= OFS_W'({s1_offs_reg, 1'b0}) + OFS_W'(s1_pos_reg);
            s2_fe_reg   <= s1_fe_reg;
            s2_err_reg  <= s1_err_reg;
        end
        if (out_ready)
        begin
            out_we_reg   <= s2_we_reg;
            out_byte_reg <= s2_byte_reg;
            out_addr_reg <= rvrd_pkg::ADDR_W'({s2_prod_reg, 1'b0})
                          + rvrd_pkg::ADDR_W'(s2_ofs_reg);
            out_fe_reg   <= s2_fe_reg;
            out_err_reg  <= s2_err_reg;
        end
    end

    assign fb.valid         = out_valid_reg;
    assign fb.write_valid   = out_we_reg;
    assign fb.write_address = out_addr_reg;
    assign fb.write_byte    = out_byte_reg;
    assign fb.frame_end     = out_fe_reg;
    assign fb.packet_error  = out_err_reg;

    // ---------------- assertions ----------------
    a_data_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> nz_mask_reg[line_cur_reg] && (rd_reg.len != '0))
        else $error("data phase on a line without data");

    a_pos_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> pos_reg < rd_reg.len)
        else $error("byte position past line length");

    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        line_total_reg <= CW'(MAX_LINES))
        else $error("line count exceeds table depth");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_acc && pkt.packet_last |=> phase_reg == PH_RTP && line_total_reg == '0
            && nz_mask_reg == '0)
        else $error("per-packet state not cleared after last word");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_acc && pkt.packet_last |=> s1_valid_reg)
        else $error("last word produced no result");

endmodule
